### hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the strict base64
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam int         GROUP_LEN   = 4;
  localparam int         MAX_BYTES   = 3;
  localparam int         MAX_RESULTS = MAX_BYTES + 1;

  typedef struct packed {
    logic [1:0] pos;
    logic [5:0] sextet_one;
    logic [5:0] sextet_two;
    logic [5:0] sextet_three;
    logic       third_was_pad;
    logic       error_seen;
  } b64d_state_t;

  typedef struct packed {
    logic [7:0] byte_two;
    logic [7:0] byte_one;
    logic [7:0] byte_zero;
    logic [1:0] num_bytes;
    logic       has_status;
    logic       status_bad;
  } b64d_result_t;

  // {not_in_alphabet, sextet}
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      v = {1'b0, 6'd63};
    end else begin
      v = {1'b1, 6'd0};
    end
    return v;
  endfunction

endpackage

### hw/rtl/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character step: updates the group state and forms the decoded bytes
// and status flag for one accepted character.
// ----------------------------------------------------------------------------
module b64d_decode (
  input  b64d_pkg::b64d_state_t  st,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output b64d_pkg::b64d_state_t  st_nxt,
  output b64d_pkg::b64d_result_t res
);

  logic [6:0] sv;
  logic       bad_char;
  logic       is_pad;
  logic       err;
  logic       pad4;
  logic [5:0] d;

  always_comb begin
    sv       = b64d_pkg::sextet_value(char_code);
    bad_char = sv[6];
    is_pad   = (char_code == b64d_pkg::PAD_CHAR);
    pad4     = is_pad;
    d        = pad4 ? 6'd0 : sv[5:0];
    err      = 1'b0;
    st_nxt   = st;
    res      = '0;

    if (!st.error_seen) begin
      case (st.pos)
        2'd0: begin
          if (bad_char) err = 1'b1;
          else st_nxt.sextet_one = sv[5:0];
        end
        2'd1: begin
          if (bad_char) err = 1'b1;
          else st_nxt.sextet_two = sv[5:0];
        end
        2'd2: begin
          if (is_pad) begin
            st_nxt.third_was_pad = 1'b1;
            st_nxt.sextet_three  = 6'd0;
          end else if (bad_char) begin
            err = 1'b1;
          end else begin
            st_nxt.sextet_three = sv[5:0];
          end
        end
        default: begin
          if (!pad4 && bad_char) err = 1'b1;
          if (st.third_was_pad && !pad4) err = 1'b1;
          if ((st.third_was_pad || pad4) && !last_char) err = 1'b1;
          if (st.third_was_pad && (st.sextet_two[3:0] != 4'd0)) err = 1'b1;
          if (!st.third_was_pad && pad4 && (st.sextet_three[1:0] != 2'd0)) err = 1'b1;
          if (!err) begin
            res.byte_zero = {st.sextet_one, st.sextet_two[5:4]};
            res.byte_one  = {st.sextet_two[3:0], st.sextet_three[5:2]};
            res.byte_two  = {st.sextet_three[1:0], d};
            if (st.third_was_pad) res.num_bytes = 2'd1;
            else if (pad4)        res.num_bytes = 2'd2;
            else                  res.num_bytes = 2'd3;
          end
        end
      endcase
      if (last_char && st.pos != 2'd3) err = 1'b1;
      if (!err) begin
        st_nxt.pos = st.pos + 2'd1;
        if (st.pos == 2'd3) st_nxt.third_was_pad = 1'b0;
      end
    end

    if (err) st_nxt.error_seen = 1'b1;

    if (last_char) begin
      res.has_status = 1'b1;
      res.status_bad = st.error_seen | err;
      st_nxt         = '0;
    end
  end

endmodule

### hw/rtl/base64_strict_decoder.sv
// ----------------------------------------------------------------------------
// base64_strict_decoder
// Strict base64 decoder: one character per transfer in, decoded bytes and a
// final status item out, one item per transfer.
//
// channel | ports                                   | direction
// in      | in_valid in_ready in_char_code in_last_char | input
// out     | out_valid out_ready out_byte out_byte_present
//         | out_end_of_message out_malformed          | output
//
// A character is decoded in the cycle it is taken; its results sit in the
// result register and leave one per cycle while out_ready is high, up to four per
// character. Characters with no result, or whose single result leaves in the
// same cycle, follow back to back; a group end holds the input while its
// bytes and status drain through the one output port.
// Reset is synchronous on rst_n and clears the group state and result count.
// ----------------------------------------------------------------------------
module base64_strict_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_end_of_message,
  output logic       out_malformed
);

  b64d_pkg::b64d_state_t  st_r, st_nxt;
  b64d_pkg::b64d_result_t res_r, res_nxt;
  logic [2:0]             rem_r, rem_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   in_xfer;
  logic                   out_xfer;

  b64d_decode u_decode (
    .st        (st_r),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  assign out_valid = (rem_r != 3'd0);
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (out_xfer) begin
      rem_nxt = rem_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
    if (in_xfer) begin
      rem_nxt = {1'b0, res_nxt.num_bytes} + {2'b00, res_nxt.has_status};
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
      if (in_xfer) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res_nxt;
  end

  always_comb begin
    out_byte           = 8'd0;
    out_byte_present   = 1'b0;
    out_end_of_message = 1'b0;
    out_malformed      = 1'b0;
    if ({1'b0, idx_r} < {1'b0, res_r.num_bytes}) begin
      out_byte_present = 1'b1;
      case (idx_r)
        2'd0:    out_byte = res_r.byte_zero;
        2'd1:    out_byte = res_r.byte_one;
        default: out_byte = res_r.byte_two;
      endcase
    end else begin
      out_end_of_message = 1'b1;
      out_malformed      = res_r.status_bad;
    end
  end

  // result count never exceeds bytes plus status
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(b64d_pkg::MAX_RESULTS))
    else $error("result count out of range");

  // status item is always the final result of its character
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_message |-> rem_r == 3'd1)
    else $error("status item not last");

  // a new character only enters as the last pending result leaves
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && out_valid |-> rem_r == 3'd1 && out_ready)
    else $error("results overwritten");

  // the message end clears the group state
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_char |=> st_r.pos == 2'd0 && !st_r.error_seen)
    else $error("state not cleared at message end");

  // byte items never carry the malformed flag
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_present |-> !out_malformed && !out_end_of_message)
    else $error("byte item flagged as status");

endmodule
